// File: rtl/core/gb5_pkg.sv
// gb5_pkg: shared types, constants and weight table of the 5x5 gaussian blur
// used by gb5_seq, gb5_window, gb5_filter and gaussian_blur_5x5, no dependencies

package gb5_pkg;

    localparam int unsigned PIX_W      = 8;
    localparam int unsigned TAPS       = 5;
    localparam int unsigned LINES      = 4;
    localparam int unsigned GROUPS     = 6;
    // eight pixels at most share one weight
    localparam int unsigned GRP_W      = PIX_W + 3;
    localparam int unsigned ROW_W      = 12;
    localparam int unsigned HGT_W      = 13;
    localparam int unsigned CFG_WID_W  = 11;
    localparam int unsigned CFG_HGT_W  = 13;
    localparam int unsigned MAX_HEIGHT = 4096;
    localparam int unsigned Q_WEIGHT   = 24;
    localparam int unsigned ADDR_W     = 3;
    localparam int unsigned DATA_W     = 32;

    localparam logic [CFG_WID_W-1:0] RESET_WIDTH  = 11'd640;
    localparam logic [CFG_HGT_W-1:0] RESET_HEIGHT = 13'd480;
    localparam logic [PIX_W-1:0]     PIX_MAX      = 8'hFF;

    // register indexes on the configuration port
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // normalised gaussian weights in q0.24, by |row offset| and |column offset|
    localparam int unsigned WEIGHT_Q24 [3][3] = '{
        '{1060177, 935603, 643030},
        '{ 935603, 825667, 567472},
        '{ 643030, 567472, 390017}
    };

    // weight groups: distinct (|dr|,|dc|) pairs up to symmetry
    localparam int unsigned GRP_ROW [GROUPS] = '{0, 0, 0, 1, 1, 2};
    localparam int unsigned GRP_COL [GROUPS] = '{0, 1, 2, 1, 2, 2};

    // one column of the window, newest row at index 0
    typedef logic [TAPS-1:0][PIX_W-1:0] gb5_col_t;
    // window, newest column at index 0
    typedef logic [TAPS-1:0][TAPS-1:0][PIX_W-1:0] gb5_win_t;

    typedef struct packed {
        logic            emit;
        logic            last;
        logic [TAPS-1:0] col_ok;
        logic [TAPS-1:0] row_ok;
    } gb5_ctl_t;

endpackage

// File: rtl/core/gb5_ram.sv
// gb5_ram: generic simple dual-port ram, one write and one registered read port
// read returns the old word when both ports hit the same address; no dependencies

module gb5_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   wen,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   ren,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/gb5_seq.sv
// gb5_seq: raster position counters, lag tracking and border masks per request
// depends on gb5_pkg

module gb5_seq
    import gb5_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               acc,
    input  logic                               restart,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]     w_eff,
    input  logic [HGT_W-1:0]                   h_eff,
    output logic [$clog2(MAX_WIDTH)-1:0]       col,
    output gb5_ctl_t                           ctl
);

    localparam int unsigned COL_W = $clog2(MAX_WIDTH);
    localparam int unsigned WC_W  = $clog2(MAX_WIDTH + 1);
    localparam int unsigned LAG_W = $clog2(2 * MAX_WIDTH + 3);
    localparam int unsigned CMP_W = WC_W + 1;

    logic [COL_W-1:0] col_reg;
    logic [LAG_W-1:0] lag_reg;
    logic [COL_W-1:0] ocol_reg;
    logic [ROW_W-1:0] orow_reg;

    logic [WC_W-1:0]  col_inc;
    logic             col_wrap;
    logic [LAG_W-1:0] lag_len;
    logic             emit;
    logic [CMP_W-1:0] ocol_ext;
    logic [CMP_W-1:0] w_ext;
    logic [HGT_W-1:0] orow_ext;
    logic             ocol_last;
    logic             orow_last;

    always_comb
    begin
        col_inc   = WC_W'(col_reg) + WC_W'(1);
        col_wrap  = (col_inc == w_eff);
        lag_len   = (LAG_W'(w_eff) << 1) + LAG_W'(2);
        emit      = (lag_reg == lag_len);
        ocol_ext  = CMP_W'(ocol_reg);
        w_ext     = CMP_W'(w_eff);
        orow_ext  = HGT_W'(orow_reg);
        ocol_last = ((ocol_ext + CMP_W'(1)) == w_ext);
        orow_last = ((orow_ext + HGT_W'(1)) == h_eff);

        ctl.emit   = emit;
        ctl.last   = emit && ocol_last && orow_last;
        // oldest column / oldest row first, centre always inside
        ctl.col_ok = {ocol_ext >= CMP_W'(2), ocol_ext >= CMP_W'(1), 1'b1,
                      (ocol_ext + CMP_W'(1)) < w_ext, (ocol_ext + CMP_W'(2)) < w_ext};
        ctl.row_ok = {orow_ext >= HGT_W'(2), orow_ext >= HGT_W'(1), 1'b1,
                      (orow_ext + HGT_W'(1)) < h_eff, (orow_ext + HGT_W'(2)) < h_eff};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            lag_reg  <= '0;
            ocol_reg <= '0;
            orow_reg <= '0;
        end
        else if (restart)
        begin
            col_reg  <= '0;
            lag_reg  <= '0;
            ocol_reg <= '0;
            orow_reg <= '0;
        end
        else if (acc)
        begin
            if (ctl.last)
            begin
                col_reg  <= '0;
                lag_reg  <= '0;
                ocol_reg <= '0;
                orow_reg <= '0;
            end
            else
            begin
                col_reg <= col_wrap ? '0 : COL_W'(col_inc);
                if (!emit)
                begin
                    lag_reg <= lag_reg + LAG_W'(1);
                end
                else
                begin
                    ocol_reg <= ocol_last ? '0 : ocol_reg + COL_W'(1);
                    if (ocol_last)
                    begin
                        orow_reg <= orow_reg + ROW_W'(1);
                    end
                end
            end
        end
    end

    assign col = col_reg;

endmodule

// File: rtl/core/gb5_window.sv
// gb5_window: four line stores in one ram word and the 5x5 window shift register
// depends on gb5_pkg and gb5_ram

module gb5_window
    import gb5_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          move,
    input  logic                          acc,
    input  logic [PIX_W-1:0]              pixel,
    input  logic [$clog2(MAX_WIDTH)-1:0]  col,
    input  gb5_ctl_t                      ctl_in,
    output gb5_win_t                      win,
    output logic                          s2_valid,
    output gb5_ctl_t                      s2_ctl
);

    localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
    localparam int unsigned LINE_W = LINES * PIX_W;

    logic              s1_valid_reg;
    logic              s1_fwd_reg;
    logic [PIX_W-1:0]  s1_pixel_reg;
    logic [COL_W-1:0]  s1_col_reg;
    gb5_ctl_t          s1_ctl_reg;
    logic [LINE_W-1:0] fwd_data_reg;
    gb5_win_t          win_reg;
    logic              s2_valid_reg;
    gb5_ctl_t          s2_ctl_reg;

    logic [LINE_W-1:0] ram_rdata;
    logic [LINE_W-1:0] line_rd;
    logic [LINE_W-1:0] line_wr;
    gb5_col_t          col_vec;
    logic              adv1;
    logic              s1_fwd_next;

    // line 0 holds the most recent row; a one-pixel-wide frame reads the
    // column that is being written, so that word is forwarded
    assign line_rd     = s1_fwd_reg ? fwd_data_reg : ram_rdata;
    assign line_wr     = {line_rd[LINE_W-PIX_W-1:0], s1_pixel_reg};
    assign col_vec     = gb5_col_t'({line_rd, s1_pixel_reg});
    assign adv1        = move && s1_valid_reg;
    assign s1_fwd_next = acc && s1_valid_reg && (col == s1_col_reg);

    gb5_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .wen   (adv1),
        .waddr (s1_col_reg),
        .wdata (line_wr),
        .ren   (acc),
        .raddr (col),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            s1_valid_reg <= acc;
            s1_fwd_reg   <= s1_fwd_next;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_pixel_reg <= pixel;
            s1_col_reg   <= col;
            s1_ctl_reg   <= ctl_in;
        end
        if (move)
        begin
            fwd_data_reg <= line_wr;
            s2_ctl_reg   <= s1_ctl_reg;
        end
        if (adv1)
        begin
            win_reg <= {win_reg[TAPS-2:0], col_vec};
        end
    end

    assign win      = win_reg;
    assign s2_valid = s2_valid_reg;
    assign s2_ctl   = s2_ctl_reg;

endmodule

// File: rtl/core/gb5_filter.sv
// gb5_filter: masked group sums, weight products, final sum and result register
// depends on gb5_pkg

module gb5_filter
    import gb5_pkg::*;
#(
    parameter int unsigned COEF_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              move,
    input  logic              s2_valid,
    input  gb5_ctl_t          s2_ctl,
    input  gb5_win_t          win,
    output logic              res_valid,
    output logic [PIX_W-1:0]  blurred_pixel,
    output logic              frame_last
);

    localparam int unsigned PROD_W = GRP_W + COEF_BITS;
    localparam int unsigned ACC_W  = PROD_W + 3;

    function automatic int unsigned coef_round(int unsigned g, int unsigned bits);
        int unsigned sh;
        int unsigned w;
        sh = Q_WEIGHT - bits;
        w  = WEIGHT_Q24[GRP_ROW[g]][GRP_COL[g]];
        if (sh == 0)
        begin
            return w;
        end
        return (w + (1 << (sh - 1))) >> sh;
    endfunction

    // weight group of window tap (row age i, column age j)
    function automatic logic [2:0] grp_of(int unsigned i, int unsigned j);
        int unsigned a;
        int unsigned b;
        int unsigned lo;
        int unsigned hi;
        logic [2:0]  g;
        a  = (i < 2) ? 2 - i : i - 2;
        b  = (j < 2) ? 2 - j : j - 2;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (lo == 0)
        begin
            g = 3'(hi);
        end
        else if (lo == 1)
        begin
            g = (hi == 1) ? 3'd3 : 3'd4;
        end
        else
        begin
            g = 3'd5;
        end
        return g;
    endfunction

    localparam logic [COEF_BITS-1:0] COEF [GROUPS] = '{
        COEF_BITS'(coef_round(0, COEF_BITS)),
        COEF_BITS'(coef_round(1, COEF_BITS)),
        COEF_BITS'(coef_round(2, COEF_BITS)),
        COEF_BITS'(coef_round(3, COEF_BITS)),
        COEF_BITS'(coef_round(4, COEF_BITS)),
        COEF_BITS'(coef_round(5, COEF_BITS))
    };

    logic [GRP_W-1:0]  grp_next [GROUPS];
    logic [GRP_W-1:0]  grp_reg  [GROUPS];
    logic              s3_res_reg;
    logic              s3_last_reg;
    logic [PROD_W-1:0] prod_next [GROUPS];
    logic [PROD_W-1:0] prod_reg  [GROUPS];
    logic              s4_res_reg;
    logic              s4_last_reg;
    logic [ACC_W-1:0]  sum;
    logic [ACC_W-1:0]  quot;
    logic [PIX_W-1:0]  pix_next;
    logic              res_valid_reg;
    logic [PIX_W-1:0]  pix_reg;
    logic              last_reg;

    // taps outside the frame are dropped before they reach the adders
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_next[g] = '0;
        end
        for (int j = 0; j < TAPS; j++)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                if (s2_ctl.col_ok[j] && s2_ctl.row_ok[i])
                begin
                    grp_next[grp_of(i, j)] = grp_next[grp_of(i, j)] + GRP_W'(win[j][i]);
                end
            end
        end
    end

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            prod_next[g] = PROD_W'(grp_reg[g]) * PROD_W'(COEF[g]);
        end
    end

    always_comb
    begin
        sum = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            sum = sum + ACC_W'(prod_reg[g]);
        end
        quot     = sum >> COEF_BITS;
        pix_next = (quot > ACC_W'(PIX_MAX)) ? PIX_MAX : quot[PIX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_res_reg    <= 1'b0;
            s4_res_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            s3_res_reg    <= s2_valid && s2_ctl.emit;
            s4_res_reg    <= s3_res_reg;
            res_valid_reg <= s4_res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            grp_reg     <= grp_next;
            s3_last_reg <= s2_ctl.last;
            prod_reg    <= prod_next;
            s4_last_reg <= s3_last_reg;
            pix_reg     <= pix_next;
            last_reg    <= s4_last_reg;
        end
    end

    assign res_valid     = res_valid_reg;
    assign blurred_pixel = pix_reg;
    assign frame_last    = last_reg;

endmodule

// File: rtl/core/gaussian_blur_5x5.sv
// gaussian_blur_5x5: streaming 5x5 gaussian blur (sigma 2) of 8-bit grey frames
// depends on gb5_pkg, gb5_seq, gb5_window, gb5_filter, gb5_ram
//
//  channel  direction  handshake                     payload
//  pixel    in         pixel_valid / pixel_stall     pixel_in, filler
//  blur     out        blur_valid / blur_stall       blurred_pixel, frame_last
//  config   in         psel, penable, pwrite, pready paddr, pwdata, prdata
//
// one request per clock unless blur_stall holds a result; the request that completes a window
// (the pixel two rows down, two columns on) passes input stage, window, group sums, products
// and result register; the first 2*width+2 requests of a frame give no result; the line ram
// and the window follow the raster position only, so frames need no clearing pass
// reset sets width 640, height 480 and restarts the frame; a register write does too
// a result held under blur_stall freezes the whole pipeline and stalls the pixel side

module gaussian_blur_5x5
    import gb5_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 1024,
    parameter int unsigned COEF_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pixel_valid,
    output logic              pixel_stall,
    input  logic [PIX_W-1:0]  pixel_in,
    input  logic              filler,
    output logic              blur_valid,
    input  logic              blur_stall,
    output logic [PIX_W-1:0]  blurred_pixel,
    output logic              frame_last,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int unsigned COL_W = $clog2(MAX_WIDTH);
    localparam int unsigned WC_W  = $clog2(MAX_WIDTH + 1);

    logic [CFG_WID_W-1:0] width_reg;
    logic [CFG_HGT_W-1:0] height_reg;
    logic [WC_W-1:0]      w_eff;
    logic [HGT_W-1:0]     h_eff;
    logic                 cfg_we;
    logic                 cfg_idx;
    logic                 move;
    logic                 pixel_acc;
    logic [PIX_W-1:0]     pixel;
    logic [COL_W-1:0]     seq_col;
    gb5_ctl_t             seq_ctl;
    gb5_win_t             win;
    logic                 s2_valid;
    gb5_ctl_t             s2_ctl;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_WIDTH:  width_reg  <= pwdata[CFG_WID_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[CFG_HGT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_WIDTH:  prdata = DATA_W'(width_reg);
            REG_HEIGHT: prdata = DATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // zero reads as one; oversize width clamps to what the line ram holds, height to MAX_HEIGHT
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WC_W'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_eff = WC_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WC_W'(width_reg);
        end

        if (height_reg == '0)
        begin
            h_eff = HGT_W'(1);
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            h_eff = HGT_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HGT_W'(height_reg);
        end
    end

    assign move        = !(blur_valid && blur_stall);
    assign pixel_stall = !move;
    assign pixel_acc   = pixel_valid && move;
    assign pixel       = filler ? '0 : pixel_in;

    gb5_seq #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .acc     (pixel_acc),
        .restart (cfg_we),
        .w_eff   (w_eff),
        .h_eff   (h_eff),
        .col     (seq_col),
        .ctl     (seq_ctl)
    );

    gb5_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .move     (move),
        .acc      (pixel_acc),
        .pixel    (pixel),
        .col      (seq_col),
        .ctl_in   (seq_ctl),
        .win      (win),
        .s2_valid (s2_valid),
        .s2_ctl   (s2_ctl)
    );

    gb5_filter #(
        .COEF_BITS (COEF_BITS)
    ) u_filter (
        .clk           (clk),
        .rst_n         (rst_n),
        .move          (move),
        .s2_valid      (s2_valid),
        .s2_ctl        (s2_ctl),
        .win           (win),
        .res_valid     (blur_valid),
        .blurred_pixel (blurred_pixel),
        .frame_last    (frame_last)
    );

    // a new frame always opens with requests that give no result
    a_restart_lag: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we || (pixel_acc && seq_ctl.last)) |=> !seq_ctl.emit)
        else $error("result flagged right after a frame restart");

    // the result behind the last of a frame belongs to the lag of the next frame
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (blur_valid && frame_last && !blur_stall) |=> !blur_valid)
        else $error("result directly follows the last pixel of a frame");

    // the frame end is only ever seen on a request that gives a result
    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_acc && seq_ctl.last) |-> (seq_ctl.emit && seq_ctl.col_ok[2]))
        else $error("frame end flagged on a request without a result");

endmodule
